@@ hdl/sha_pad_pkg.sv @@
// Shared types and constants for the SHA-1/SHA-256 message padder.
// No dependencies; imported by the padder and its checker.
package sha_pad_pkg;

    localparam int COUNT_W   = 61;
    localparam int WORD_W    = 32;
    localparam int SLOT_W    = 4;

    // Slot before the high length word, and the last slot of a block.
    localparam logic [SLOT_W-1:0] SLOT_BEFORE_LEN = 4'd13;
    localparam logic [SLOT_W-1:0] SLOT_LAST       = 4'd15;

    localparam logic [1:0] LANE_FULL = 2'd3;
    localparam logic [7:0] PAD_MARK  = 8'h80;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       has_byte;
        logic       message_end;
    } msg_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              block_end;
        logic              padding_done;
    } blk_item_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MARK,
        PH_ZERO,
        PH_HI,
        PH_LO
    } phase_t;

endpackage

@@ hdl/sha_message_padder.sv @@
// SHA-1/SHA-256 message padder: bytes in, big-endian words in 512-bit blocks out.
// Depends on sha_pad_pkg for the item structs, the phase enum and constants.
//
// The padder takes one message item per cycle while msg_ready is high.
// Bytes are packed big-endian into 32-bit words; each fourth byte loads a
// word into the output register as it is accepted, and stalls input only
// while that register holds an untaken word. An item with message_end
// starts the padding sequence: the word holding the 0x80 marker, zero words
// up to and including slot 13 of the block (running through a whole extra
// block when the marker word lands in slot 14 or 15), then the 64-bit bit
// length as a high and a low word. The padding words leave one per cycle
// from the phase sequencer unless the output stalls; a message end holds
// the input until the low length word is registered. The 61-bit byte
// length counter wraps, so the bit length wraps at 2^64. After the low
// length word, message state clears and a new message may start at once.
module sha_message_padder
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    output logic                   msg_ready,
    input  sha_pad_pkg::msg_item_t msg_item,
    output logic                   blk_valid,
    input  logic                   blk_ready,
    output sha_pad_pkg::blk_item_t blk_item
);
    import sha_pad_pkg::*;

    phase_t             phase_reg,      phase_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [23:0]        partial_reg,    partial_next;
    logic [1:0]         lane_reg,       lane_next;
    logic [SLOT_W-1:0]  slot_reg,       slot_next;
    logic               out_valid_reg,  out_valid_next;
    blk_item_t          out_item_reg,   out_item_next;

    logic               out_free;
    logic               accept;
    logic [63:0]        bit_len;
    logic [WORD_W-1:0]  mark_word;

    // The output register can take a word when empty or being drained now.
    assign out_free  = !out_valid_reg || blk_ready;
    // Only a byte that completes a word needs the output register.
    assign msg_ready = (phase_reg == PH_IDLE) && (out_free || (lane_reg != LANE_FULL));
    assign accept    = msg_valid && msg_ready;
    assign bit_len   = {byte_count_reg, 3'b000};

    // Marker word: buffered bytes first, then 0x80, then zero fill.
    always_comb
    begin
        unique case (lane_reg)
            2'd0:    mark_word = {PAD_MARK, 24'h000000};
            2'd1:    mark_word = {partial_reg[7:0], PAD_MARK, 16'h0000};
            2'd2:    mark_word = {partial_reg[15:0], PAD_MARK, 8'h00};
            default: mark_word = {partial_reg[23:0], PAD_MARK};
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        partial_next    = partial_reg;
        lane_next       = lane_reg;
        slot_next       = slot_reg;
        out_valid_next  = out_valid_reg && !blk_ready;
        out_item_next   = out_item_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (accept)
                begin
                    if (msg_item.has_byte)
                    begin
                        byte_count_next = byte_count_reg + COUNT_W'(1);
                        if (lane_reg == LANE_FULL)
                        begin
                            out_valid_next             = 1'b1;
                            out_item_next.word         = {partial_reg, msg_item.message_byte};
                            out_item_next.block_end    = (slot_reg == SLOT_LAST);
                            out_item_next.padding_done = 1'b0;
                            slot_next                  = slot_reg + SLOT_W'(1);
                            partial_next               = '0;
                            lane_next                  = '0;
                        end
                        else
                        begin
                            partial_next = {partial_reg[15:0], msg_item.message_byte};
                            lane_next    = lane_reg + 2'd1;
                        end
                    end
                    if (msg_item.message_end)
                    begin
                        phase_next = PH_MARK;
                    end
                end
            end
            PH_MARK, PH_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.word         = (phase_reg == PH_MARK) ? mark_word : '0;
                    out_item_next.block_end    = (slot_reg == SLOT_LAST);
                    out_item_next.padding_done = 1'b0;
                    slot_next                  = slot_reg + SLOT_W'(1);
                    phase_next = (slot_reg == SLOT_BEFORE_LEN) ? PH_HI : PH_ZERO;
                end
            end
            PH_HI:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.word         = bit_len[63:32];
                    out_item_next.block_end    = 1'b0;
                    out_item_next.padding_done = 1'b0;
                    slot_next                  = slot_reg + SLOT_W'(1);
                    phase_next                 = PH_LO;
                end
            end
            PH_LO:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.word         = bit_len[31:0];
                    out_item_next.block_end    = 1'b1;
                    out_item_next.padding_done = 1'b1;
                    // The message is closed: start the next one from zero.
                    slot_next                  = '0;
                    byte_count_next            = '0;
                    partial_next               = '0;
                    lane_next                  = '0;
                    phase_next                 = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_count_reg <= '0;
            partial_reg    <= '0;
            lane_reg       <= '0;
            slot_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            partial_reg    <= partial_next;
            lane_reg       <= lane_next;
            slot_reg       <= slot_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign blk_valid = out_valid_reg;
    assign blk_item  = out_item_reg;

endmodule

@@ hdl/sha_pad_checker.sv @@
// Port-level checks for the message padder, bound to sha_message_padder.
// Depends on sha_pad_pkg for the item structs.
module sha_pad_checker
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   msg_valid,
    input logic                   msg_ready,
    input sha_pad_pkg::msg_item_t msg_item,
    input logic                   blk_valid,
    input logic                   blk_ready,
    input sha_pad_pkg::blk_item_t blk_item
);
    import sha_pad_pkg::*;

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid && !blk_ready |=> blk_valid && $stable(blk_item))
        else $error("result item changed while stalled");

    // The final length word always closes a block.
    a_done_block: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid && blk_item.padding_done |-> blk_item.block_end)
        else $error("padding done outside the last slot of a block");

    // A message end holds the input while the padding words go out.
    a_end_holds: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && msg_item.message_end |=> !msg_ready)
        else $error("input taken right after a message end");

endmodule

bind sha_message_padder sha_pad_checker u_sha_pad_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg_item  (msg_item),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk_item  (blk_item)
);
